// ===== rtl/izvd_pkg.sv =====
// ----------------------------------------------------------------------------
// IMU zero-velocity detector package
// Shared widths, register indexes and helpers for the detector.
// ----------------------------------------------------------------------------
package izvd_pkg;

   localparam int COMP_W  = 32;             // one vector component
   localparam int ROOT_W  = 32;             // norm width
   localparam int RAD_W   = 2 * ROOT_W;     // sum of squares width
   localparam int CSR_AW  = 2;
   localparam int CSR_DW  = 32;
   localparam int SPEED_FRAC = 24;
   localparam int TURN_FRAC  = 30;

   typedef enum logic [CSR_AW-1:0] {
      CSR_SPEED_LIMIT  = 2'd0,
      CSR_TURN_LIMIT   = 2'd1,
      CSR_SPEED_SPREAD = 2'd2,
      CSR_TURN_SPREAD  = 2'd3
   } csr_index_type;

   localparam logic [CSR_DW-1:0] SPEED_LIMIT_RST  = 32'd1644167;
   localparam logic [CSR_DW-1:0] TURN_LIMIT_RST   = 32'd117447;
   localparam logic [CSR_DW-1:0] SPEED_SPREAD_RST = 32'd82208;
   localparam logic [CSR_DW-1:0] TURN_SPREAD_RST  = 32'd391;

   // magnitude of a two's complement component; -2^31 maps to 2^31
   function automatic logic [COMP_W-1:0] comp_mag(input logic [COMP_W-1:0] v);
      comp_mag = v[COMP_W-1] ? (~v + COMP_W'(1)) : v;
   endfunction

endpackage

// ===== rtl/izvd_req_if.sv =====
// ----------------------------------------------------------------------------
// IMU epoch channel
// Valid/ready channel carrying one velocity and one angle increment.
// ----------------------------------------------------------------------------
interface izvd_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] dvel_x;
   logic signed [31:0] dvel_y;
   logic signed [31:0] dvel_z;
   logic signed [31:0] dang_x;
   logic signed [31:0] dang_y;
   logic signed [31:0] dang_z;

   modport source (output valid, dvel_x, dvel_y, dvel_z, dang_x, dang_y, dang_z,
                   input ready);
   modport sink   (input valid, dvel_x, dvel_y, dvel_z, dang_x, dang_y, dang_z,
                   output ready);
endinterface

// ===== rtl/izvd_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Detector result channel
// Valid/ready channel carrying the three stationary flags.
// ----------------------------------------------------------------------------
interface izvd_rsp_if;
   logic valid;
   logic ready;
   logic stationary;
   logic instant_still;
   logic window_still;

   modport source (output valid, stationary, instant_still, window_still,
                   input ready);
   modport sink   (input valid, stationary, instant_still, window_still,
                   output ready);
endinterface

// ===== rtl/izvd_sqrt.sv =====
// ----------------------------------------------------------------------------
// Digit-serial integer square root
// Restoring root, one radicand digit pair and one root bit per cycle.
// ----------------------------------------------------------------------------
module izvd_sqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [izvd_pkg::RAD_W-1:0] radicand,
   output logic                       done,
   output logic [izvd_pkg::ROOT_W-1:0] root
);
   import izvd_pkg::*;

   localparam int REM_W = ROOT_W + 1;
   localparam int SH_W  = ROOT_W + 3;
   localparam int CNT_W = $clog2(ROOT_W);

   logic [RAD_W-1:0]  rad_ff;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [CNT_W-1:0]  cnt_ff;
   logic              run_ff, done_ff;
   logic [SH_W-1:0]   rem_sh, trial;
   logic              fits;

   always_comb begin
      rem_sh  = {rem_ff, rad_ff[RAD_W-1 -: 2]};
      trial   = {1'b0, root_ff, 2'b01};
      fits    = rem_sh >= trial;
      rem_in  = fits ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
      root_in = {root_ff[ROOT_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= run_ff && !start && (cnt_ff == CNT_W'(ROOT_W - 1));
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(ROOT_W - 1)) begin
               run_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (run_ff) begin
         rad_ff  <= rad_ff << 2;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule

// ===== rtl/imu_zero_velocity_detector.sv =====
// Flow: each epoch is squared, passed through the two square root units (start,
// digits, done), then every window pair i <= j is read and the pair pipeline
// drains, and a compare state forms the result.
// A new epoch is accepted only when the previous one is through; a result word
// still waiting on the output holds the compare state and with it the next accept.
// Reset (synchronous) restores the limit registers and empties the window.
// ----------------------------------------------------------------------------
// IMU zero-velocity detector
// Norm, window mean and window variance tests on velocity and angle increments.
// ----------------------------------------------------------------------------
module imu_zero_velocity_detector #(
   parameter int WINDOW_LEN = 5
) (
   input  logic                         clock,
   input  logic                         reset,
   izvd_req_if.sink                     req_bus,
   izvd_rsp_if.source                   rsp_bus,
   input  logic                         csr_we,
   input  logic [izvd_pkg::CSR_AW-1:0]  csr_index,
   input  logic [izvd_pkg::CSR_DW-1:0]  csr_wdata
);
   import izvd_pkg::*;

   localparam int IDX_W  = $clog2(WINDOW_LEN);
   localparam int FILL_W = $clog2(WINDOW_LEN + 1);
   localparam int SUM_W  = ROOT_W + FILL_W;
   localparam int DEV_W  = RAD_W + 2 * FILL_W;
   localparam int NSQ_W  = 2 * FILL_W;
   localparam int BND_W  = CSR_DW + NSQ_W;

   typedef enum logic [2:0] {
      S_IDLE, S_SQ, S_ROOT, S_SCAN, S_TEST
   } state_type;

   state_type         state_ff;
   logic [CSR_DW-1:0] speed_limit_ff, turn_limit_ff, speed_spread_ff, turn_spread_ff;

   logic [COMP_W-1:0] mag_ff [6];
   logic [2:0]        sq_cnt_ff;
   logic [RAD_W-1:0]  sq_prod_ff, acc_v_ff, acc_a_ff;
   logic              root_start_ff;
   logic              v_done, a_done, root_done;
   logic [ROOT_W-1:0] v_root, a_root;

   logic [2*ROOT_W-1:0] win_mem [WINDOW_LEN];
   logic [2*ROOT_W-1:0] rd_a_ff, rd_b_ff;
   logic [IDX_W-1:0]    wptr_ff, pi_ff, pj_ff;
   logic [FILL_W-1:0]   fill_ff, fill_in, last_idx;
   logic [NSQ_W-1:0]    nsq_ff;
   logic                issuing_ff, v1_ff, v2_ff, v3_ff, diag1_ff;
   logic [ROOT_W-1:0]   dsp_ff, dtn_ff;
   logic [RAD_W-1:0]    psp_ff, ptn_ff;
   logic [SUM_W-1:0]    sum_sp_ff, sum_tn_ff;
   logic [DEV_W-1:0]    dev_sp_ff, dev_tn_ff;
   logic                inst_ff;

   logic                rsp_valid_ff, stat_ff, inst_out_ff, win_out_ff;

   logic [ROOT_W-1:0]   sp_a, sp_b, tn_a, tn_b;
   logic                out_free, win_ok;
   logic [SUM_W-1:0]    mean_bnd_sp, mean_bnd_tn;
   logic [DEV_W-1:0]    var_bnd_sp, var_bnd_tn;

   izvd_sqrt u_sqrt_vel (
      .clock(clock), .reset(reset), .start(root_start_ff),
      .radicand(acc_v_ff), .done(v_done), .root(v_root)
   );

   izvd_sqrt u_sqrt_ang (
      .clock(clock), .reset(reset), .start(root_start_ff),
      .radicand(acc_a_ff), .done(a_done), .root(a_root)
   );

   always_comb begin
      root_done = v_done && a_done;
      fill_in  = (fill_ff == FILL_W'(WINDOW_LEN)) ? fill_ff : fill_ff + FILL_W'(1);
      last_idx = fill_ff - FILL_W'(1);
      sp_a = rd_a_ff[2*ROOT_W-1:ROOT_W];
      sp_b = rd_b_ff[2*ROOT_W-1:ROOT_W];
      tn_a = rd_a_ff[ROOT_W-1:0];
      tn_b = rd_b_ff[ROOT_W-1:0];
      out_free    = !rsp_valid_ff || rsp_bus.ready;
      mean_bnd_sp = SUM_W'(speed_limit_ff) * SUM_W'(fill_ff);
      mean_bnd_tn = SUM_W'(turn_limit_ff) * SUM_W'(fill_ff);
      var_bnd_sp  = DEV_W'(BND_W'(speed_spread_ff) * BND_W'(nsq_ff)) << SPEED_FRAC;
      var_bnd_tn  = DEV_W'(BND_W'(turn_spread_ff) * BND_W'(nsq_ff)) << TURN_FRAC;
      win_ok = (sum_sp_ff < mean_bnd_sp) && (sum_tn_ff < mean_bnd_tn)
            && (dev_sp_ff < var_bnd_sp) && (dev_tn_ff < var_bnd_tn);
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         speed_limit_ff  <= SPEED_LIMIT_RST;
         turn_limit_ff   <= TURN_LIMIT_RST;
         speed_spread_ff <= SPEED_SPREAD_RST;
         turn_spread_ff  <= TURN_SPREAD_RST;
         fill_ff         <= '0;
         wptr_ff         <= '0;
         sq_cnt_ff       <= '0;
         root_start_ff   <= 1'b0;
         issuing_ff      <= 1'b0;
         v1_ff           <= 1'b0;
         v2_ff           <= 1'b0;
         v3_ff           <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_SPEED_LIMIT:  speed_limit_ff  <= csr_wdata;
               CSR_TURN_LIMIT:   turn_limit_ff   <= csr_wdata;
               CSR_SPEED_SPREAD: speed_spread_ff <= csr_wdata;
               CSR_TURN_SPREAD:  turn_spread_ff  <= csr_wdata;
               default: ;
            endcase
         end
         if (state_ff == S_TEST && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_bus.ready) rsp_valid_ff <= 1'b0;
         root_start_ff <= (state_ff == S_SQ) && (sq_cnt_ff == 3'd6);
         v1_ff <= (state_ff == S_SCAN) && issuing_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         unique case (state_ff)
            S_IDLE: begin
               if (req_bus.valid) begin
                  sq_cnt_ff <= '0;
                  state_ff  <= S_SQ;
               end
            end
            S_SQ: begin
               sq_cnt_ff <= sq_cnt_ff + 3'd1;
               if (sq_cnt_ff == 3'd6) begin
                  state_ff <= S_ROOT;
               end
            end
            S_ROOT: begin
               if (root_done) begin
                  fill_ff    <= fill_in;
                  wptr_ff    <= (wptr_ff == IDX_W'(WINDOW_LEN - 1)) ? '0
                                : wptr_ff + IDX_W'(1);
                  pi_ff      <= '0;
                  pj_ff      <= '0;
                  issuing_ff <= 1'b1;
                  state_ff   <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (issuing_ff) begin
                  // walk pairs i <= j
                  if (FILL_W'(pj_ff) == last_idx) begin
                     if (FILL_W'(pi_ff) == last_idx) begin
                        issuing_ff <= 1'b0;
                     end else begin
                        pi_ff <= pi_ff + IDX_W'(1);
                        pj_ff <= pi_ff + IDX_W'(1);
                     end
                  end else begin
                     pj_ff <= pj_ff + IDX_W'(1);
                  end
               end else if (!v1_ff && !v2_ff && !v3_ff) begin
                  state_ff <= S_TEST;
               end
            end
            S_TEST: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_bus.valid) begin
         mag_ff[0] <= comp_mag(req_bus.dvel_x);
         mag_ff[1] <= comp_mag(req_bus.dvel_y);
         mag_ff[2] <= comp_mag(req_bus.dvel_z);
         mag_ff[3] <= comp_mag(req_bus.dang_x);
         mag_ff[4] <= comp_mag(req_bus.dang_y);
         mag_ff[5] <= comp_mag(req_bus.dang_z);
         acc_v_ff  <= '0;
         acc_a_ff  <= '0;
      end
      if (state_ff == S_SQ) begin
         if (sq_cnt_ff < 3'd6) sq_prod_ff <= mag_ff[sq_cnt_ff] * mag_ff[sq_cnt_ff];
         if (sq_cnt_ff >= 3'd1 && sq_cnt_ff <= 3'd3) acc_v_ff <= acc_v_ff + sq_prod_ff;
         if (sq_cnt_ff >= 3'd4) acc_a_ff <= acc_a_ff + sq_prod_ff;
      end
      if (state_ff == S_ROOT && root_done) begin
         win_mem[wptr_ff] <= {v_root, a_root};
         inst_ff   <= (v_root < speed_limit_ff) && (a_root < turn_limit_ff);
         nsq_ff    <= NSQ_W'(fill_in) * NSQ_W'(fill_in);
         sum_sp_ff <= '0;
         sum_tn_ff <= '0;
         dev_sp_ff <= '0;
         dev_tn_ff <= '0;
      end
      if (state_ff == S_SCAN && issuing_ff) begin
         rd_a_ff  <= win_mem[pi_ff];
         rd_b_ff  <= win_mem[pj_ff];
         diag1_ff <= pi_ff == pj_ff;
      end
      if (v1_ff) begin
         dsp_ff <= (sp_a >= sp_b) ? sp_a - sp_b : sp_b - sp_a;
         dtn_ff <= (tn_a >= tn_b) ? tn_a - tn_b : tn_b - tn_a;
         if (diag1_ff) begin
            sum_sp_ff <= sum_sp_ff + SUM_W'(sp_a);
            sum_tn_ff <= sum_tn_ff + SUM_W'(tn_a);
         end
      end
      if (v2_ff) begin
         psp_ff <= dsp_ff * dsp_ff;
         ptn_ff <= dtn_ff * dtn_ff;
      end
      // sum over pairs of squared differences equals n*sumsq - sum^2
      if (v3_ff) begin
         dev_sp_ff <= dev_sp_ff + DEV_W'(psp_ff);
         dev_tn_ff <= dev_tn_ff + DEV_W'(ptn_ff);
      end
      if (state_ff == S_TEST && out_free) begin
         stat_ff     <= inst_ff && win_ok;
         inst_out_ff <= inst_ff;
         win_out_ff  <= win_ok;
      end
   end

   assign req_bus.ready         = state_ff == S_IDLE;
   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.stationary    = stat_ff;
   assign rsp_bus.instant_still = inst_out_ff;
   assign rsp_bus.window_still  = win_out_ff;
endmodule

// ===== rtl/izvd_checker.sv =====
// ----------------------------------------------------------------------------
// IMU zero-velocity detector checker
// Port-level properties of the detector, bound to the top level.
// ----------------------------------------------------------------------------
module izvd_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic stationary,
   input logic instant_still,
   input logic window_still
);
   a_stat_and : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (stationary == (instant_still && window_still)))
      else $error("stationary flag disagrees with its two tests");

   a_one_at_a_time : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("new word taken while one is in work");

   a_reset_quiet : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result word dropped before taken");
endmodule

bind imu_zero_velocity_detector izvd_checker u_izvd_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_bus.valid),
   .req_ready(req_bus.ready),
   .rsp_valid(rsp_bus.valid),
   .rsp_ready(rsp_bus.ready),
   .stationary(rsp_bus.stationary),
   .instant_still(rsp_bus.instant_still),
   .window_still(rsp_bus.window_still)
);

// ===== dv/imu_zero_velocity_detector_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU zero-velocity detector testbench
// Sends IMU epochs through the request channel and predicts the three
// stationary flags in the testbench. The prediction keeps its own windows of
// norms and its own limit registers. Each returned word is checked against
// the oldest prediction. Both channels idle at random, and the limits are
// rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module imu_zero_velocity_detector_tb;
   import izvd_pkg::*;

   localparam int DEPTH = 5;
   localparam int LATENCY = 70;

   typedef struct {
      logic signed [31:0] dvel [3];
      logic signed [31:0] dang [3];
   } epoch_type;

   typedef struct packed {
      logic stationary;
      logic instant_still;
      logic window_still;
   } flags_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_AW-1:0] csr_index;
   logic [CSR_DW-1:0] csr_wdata;

   izvd_req_if req_bus ();
   izvd_rsp_if rsp_bus ();

   imu_zero_velocity_detector #(.WINDOW_LEN(DEPTH)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // limit registers as the block should hold them
   logic [31:0] speed_lim, turn_lim, speed_spread, turn_spread;
   logic [31:0] speed_hist [DEPTH];
   logic [31:0] turn_hist [DEPTH];
   int          hist_fill;
   flags_type   pending_flags [$];
   int          mismatches;
   bit          no_stall;

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   function automatic logic [31:0] norm3(input logic signed [31:0] c [3]);
      logic [63:0] s;
      logic [63:0] m;
      logic [31:0] root;
      logic [31:0] trial;
      s = 64'd0;
      for (int i = 0; i < 3; i++) begin
         m = c[i][31] ? (64'h1_0000_0000 - {32'd0, c[i]}) : {32'd0, c[i]};
         s += m * m;
      end
      root = 32'd0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (32'd1 << b);
         if (64'(trial) * 64'(trial) <= s) root = trial;
      end
      return root;
   endfunction

   function automatic bit window_calm(input logic [31:0] w [DEPTH], input int n,
                                      input logic [31:0] lim, input logic [31:0] spread,
                                      input int frac);
      logic [127:0] sum, sumsq, dev, bound;
      sum = 128'd0;
      sumsq = 128'd0;
      for (int i = 0; i < n; i++) begin
         sum += 128'(w[i]);
         sumsq += 128'(w[i]) * 128'(w[i]);
      end
      if (!(sum < 128'(lim) * 128'(n))) return 1'b0;
      dev = 128'(n) * sumsq - sum * sum;
      bound = (128'(spread) * 128'(n) * 128'(n)) << frac;
      return dev < bound;
   endfunction

   function automatic flags_type predict_flags(input epoch_type e);
      logic [31:0] vn, an;
      flags_type f;
      vn = norm3(e.dvel);
      an = norm3(e.dang);
      f.instant_still = (vn < speed_lim) && (an < turn_lim);
      if (hist_fill >= DEPTH) begin
         // drop the oldest norm
         for (int i = 0; i < DEPTH - 1; i++) begin
            speed_hist[i] = speed_hist[i+1];
            turn_hist[i] = turn_hist[i+1];
         end
         speed_hist[DEPTH-1] = vn;
         turn_hist[DEPTH-1] = an;
      end else begin
         speed_hist[hist_fill] = vn;
         turn_hist[hist_fill] = an;
         hist_fill++;
      end
      f.window_still = window_calm(speed_hist, hist_fill, speed_lim, speed_spread,
                                   SPEED_FRAC)
                    && window_calm(turn_hist, hist_fill, turn_lim, turn_spread, TURN_FRAC);
      f.stationary = f.instant_still && f.window_still;
      return f;
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (no_stall || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [31:0] signed_comp(input logic [31:0] mag_max);
      logic [31:0] m;
      m = $urandom_range(0, mag_max);
      return $urandom_range(0, 1) ? -$signed(m) : $signed(m);
   endfunction

   // mostly quiet epochs so the window tests get passed, some noise
   function automatic epoch_type random_epoch();
      epoch_type e;
      int r;
      r = $urandom_range(0, 99);
      for (int i = 0; i < 3; i++) begin
         if (r < 65) begin
            e.dvel[i] = signed_comp(32'd700000);
            e.dang[i] = signed_comp(32'd50000);
         end else if (r < 85) begin
            e.dvel[i] = signed_comp(32'd2500000);
            e.dang[i] = signed_comp(32'd180000);
         end else begin
            e.dvel[i] = $urandom;
            e.dang[i] = $urandom;
         end
      end
      return e;
   endfunction

   task automatic send_epoch(input epoch_type e);
      int g;
      g = gap_len();
      if (g > 0) begin
         @(negedge clock);
         req_bus.valid = 1'b0;
         repeat (g - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.dvel_x = e.dvel[0];
      req_bus.dvel_y = e.dvel[1];
      req_bus.dvel_z = e.dvel[2];
      req_bus.dang_x = e.dang[0];
      req_bus.dang_y = e.dang[1];
      req_bus.dang_z = e.dang[2];
      req_bus.valid = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      pending_flags = {pending_flags, predict_flags(e)};
   endtask

   task automatic go_idle();
      @(negedge clock);
      req_bus.valid = 1'b0;
      wait (pending_flags.size() == 0);
      repeat (LATENCY) @(negedge clock);
   endtask

   task automatic write_limit(input csr_index_type idx, input logic [31:0] val);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      case (idx)
         CSR_SPEED_LIMIT:  speed_lim = val;
         CSR_TURN_LIMIT:   turn_lim = val;
         CSR_SPEED_SPREAD: speed_spread = val;
         CSR_TURN_SPREAD:  turn_spread = val;
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic set_limits(input logic [31:0] s, input logic [31:0] t,
                             input logic [31:0] ss, input logic [31:0] ts);
      go_idle();
      write_limit(CSR_SPEED_LIMIT, s);
      write_limit(CSR_TURN_LIMIT, t);
      write_limit(CSR_SPEED_SPREAD, ss);
      write_limit(CSR_TURN_SPREAD, ts);
   endtask

   task automatic send_uniform(input logic signed [31:0] v, input logic signed [31:0] a);
      epoch_type e;
      for (int i = 0; i < 3; i++) begin
         e.dvel[i] = v;
         e.dang[i] = a;
      end
      send_epoch(e);
   endtask

   // reset limits, window growing from empty, extreme components
   task automatic test_directed();
      repeat (6) send_uniform(32'sd0, 32'sd0);
      send_uniform(32'sd1000, 32'sd100);
      send_uniform(32'sh7FFFFFFF, 32'sh7FFFFFFF);
      send_uniform(-32'sh80000000, -32'sh80000000);
      send_uniform(32'sd0, -32'sh80000000);
      send_uniform(-32'sh80000000, 32'sd0);
      send_uniform(-32'sd1, 32'sd1);
      repeat (5) send_uniform(32'sd500000, -32'sd30000);
      send_uniform(32'sd949240, 32'sd0);
      send_uniform(32'sd0, 32'sd67808);
   endtask

   task automatic test_random_phase(input int count);
      for (int i = 0; i < count; i++) send_epoch(random_epoch());
   endtask

   task automatic test_zero_limits();
      set_limits(32'd0, 32'd0, 32'd0, 32'd0);
      repeat (6) send_uniform(32'sd0, 32'sd0);
      test_random_phase(30);
   endtask

   task automatic test_max_limits();
      set_limits(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
      send_uniform(-32'sh80000000, -32'sh80000000);
      send_uniform(32'sh7FFFFFFF, 32'sd0);
      test_random_phase(60);
   endtask

   task automatic test_random_limits();
      for (int k = 0; k < 4; k++) begin
         set_limits($urandom_range(200000, 3000000), $urandom_range(20000, 200000),
                    $urandom, $urandom_range(0, 2000));
         no_stall = (k == 1);
         test_random_phase(150);
         no_stall = 1'b0;
      end
   endtask

   always @(negedge clock) begin
      if (reset || no_stall) begin
         rsp_bus.ready <= 1'b1;
      end else begin
         int r;
         r = $urandom_range(0, 99);
         if (r < 60) rsp_bus.ready <= 1'b1;
         else if (r < 97) rsp_bus.ready <= 1'b0;
         else begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(8, 40)) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         flags_type got, want;
         got = '{rsp_bus.stationary, rsp_bus.instant_still, rsp_bus.window_still};
         if (pending_flags.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word: got %b", got);
         end else begin
            want = pending_flags.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("flag mismatch: stationary %b/%b instant %b/%b window %b/%b",
                           want.stationary, got.stationary, want.instant_still,
                           got.instant_still, want.window_still, got.window_still);
            end
         end
      end
   end

   initial begin
      #4000000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      mismatches = 0;
      no_stall = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_SPEED_LIMIT;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.dvel_x = '0;
      req_bus.dvel_y = '0;
      req_bus.dvel_z = '0;
      req_bus.dang_x = '0;
      req_bus.dang_y = '0;
      req_bus.dang_z = '0;
      speed_lim = SPEED_LIMIT_RST;
      turn_lim = TURN_LIMIT_RST;
      speed_spread = SPEED_SPREAD_RST;
      turn_spread = TURN_SPREAD_RST;
      hist_fill = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_random_phase(300);
      test_zero_limits();
      test_max_limits();
      test_random_limits();
      set_limits(SPEED_LIMIT_RST, TURN_LIMIT_RST, SPEED_SPREAD_RST, TURN_SPREAD_RST);
      test_random_phase(500);

      @(negedge clock);
      req_bus.valid = 1'b0;
      wait (pending_flags.size() == 0);
      repeat (LATENCY) @(posedge clock);
      if (mismatches == 0 && pending_flags.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/izvd_pkg.sv
rtl/izvd_req_if.sv
rtl/izvd_rsp_if.sv
rtl/izvd_sqrt.sv
rtl/imu_zero_velocity_detector.sv
rtl/izvd_checker.sv
dv/imu_zero_velocity_detector_tb.sv
